FILE: sv/ps2mct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mct_pkg
// Shared constants and types of the PS/2 mouse cursor tracker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

    localparam int COORD_BITS = 12;
    localparam int SIZE_BITS  = 13;
    localparam int MOVE_BITS  = 9;
    localparam int BYTE_BITS  = 8;

    localparam int IN_TDATA_W  = BYTE_BITS;
    localparam int OUT_W       = 4 * COORD_BITS + 2 * MOVE_BITS + 3;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = SIZE_BITS'(640);
    localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = SIZE_BITS'(480);

    // header byte bits
    localparam int HDR_LEFT   = 0;
    localparam int HDR_RIGHT  = 1;
    localparam int HDR_MIDDLE = 2;
    localparam int HDR_XSIGN  = 4;
    localparam int HDR_YSIGN  = 5;
    localparam int HDR_XOVF   = 6;
    localparam int HDR_YOVF   = 7;

    typedef enum logic [0:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        POS_HEADER = 2'd0,
        POS_X      = 2'd1,
        POS_Y      = 2'd2
    } byte_pos_t;

    typedef struct packed {
        logic                        drop;
        logic [COORD_BITS-1:0]       cursor_x;
        logic [COORD_BITS-1:0]       cursor_y;
        logic [COORD_BITS-1:0]       prior_x;
        logic [COORD_BITS-1:0]       prior_y;
        logic signed [MOVE_BITS-1:0] move_x;
        logic signed [MOVE_BITS-1:0] move_y;
        logic                        left_button;
        logic                        right_button;
        logic                        middle_button;
    } result_t;

endpackage

FILE: sv/ps2mct_cursor_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mct_cursor_calc
// Decodes one complete packet and computes the clamped new cursor position.
// ----------------------------------------------------------------------------
module ps2mct_cursor_calc
    import ps2mct_pkg::*;
(
    input  logic [BYTE_BITS-1:0]  header,
    input  logic [BYTE_BITS-1:0]  x_byte,
    input  logic [BYTE_BITS-1:0]  y_byte,
    input  logic [COORD_BITS-1:0] pos_x,
    input  logic [COORD_BITS-1:0] pos_y,
    input  logic [SIZE_BITS-1:0]  screen_width,
    input  logic [SIZE_BITS-1:0]  screen_height,
    output result_t               result
);

    localparam int SUM_W = COORD_BITS + 2;
    localparam logic [COORD_BITS-1:0] CMAX = {COORD_BITS{1'b1}};

    function automatic logic [COORD_BITS-1:0] clamp_limit(input logic [SIZE_BITS-1:0] size);
        logic [SIZE_BITS-1:0] lim;
        lim = (size == '0) ? '0 : size - SIZE_BITS'(1);
        if (32'(lim) > 32'(CMAX))
            return CMAX;
        return COORD_BITS'(lim);
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_coord(input logic signed [SUM_W-1:0] v,
                                                          input logic [COORD_BITS-1:0] lim);
        if (v < 0)
            return '0;
        if (v > $signed({2'b00, lim}))
            return lim;
        return v[COORD_BITS-1:0];
    endfunction

    logic signed [MOVE_BITS-1:0] mx;
    logic signed [MOVE_BITS-1:0] my;
    logic signed [SUM_W-1:0]     sum_x;
    logic signed [SUM_W-1:0]     sum_y;

    assign mx = {header[HDR_XSIGN], x_byte};
    assign my = {header[HDR_YSIGN], y_byte};

    // screen y grows downward, so subtract the vertical move
    assign sum_x = $signed({2'b00, pos_x}) + SUM_W'(mx);
    assign sum_y = $signed({2'b00, pos_y}) - SUM_W'(my);

    always_comb
    begin
        result.drop          = header[HDR_XOVF] | header[HDR_YOVF];
        result.cursor_x      = clamp_coord(sum_x, clamp_limit(screen_width));
        result.cursor_y      = clamp_coord(sum_y, clamp_limit(screen_height));
        result.prior_x       = pos_x;
        result.prior_y       = pos_y;
        result.move_x        = mx;
        result.move_y        = my;
        result.left_button   = header[HDR_LEFT];
        result.right_button  = header[HDR_RIGHT];
        result.middle_button = header[HDR_MIDDLE];
    end

endmodule

FILE: sv/ps2_mouse_cursor_tracker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_cursor_tracker_unit
// Assembles three-byte PS/2 mouse packets, tracks buttons and a clamped
// cursor position, and emits one word per packet without overflow.
// ----------------------------------------------------------------------------
// channel   direction  signals                           content
// s_axis    in         s_axis_tvalid/tready/tdata[7:0]   received mouse byte
// m_axis    out        m_axis_tvalid/tready/tdata[71:0]  cursor update word
// cfg       in         cfg_valid/ready/index/data[12:0]  screen width, height
//
// One byte is taken per cycle; the third byte of a packet loads the result
// register in the same cycle, so the word appears in the cycle after.
// Byte intake stalls only while a result waits and m_axis_tready is low.
// Reset: byte count and cursor at zero, buttons released, 640 x 480 screen.
// Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
module ps2_mouse_cursor_tracker_unit
    import ps2mct_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [7:0] rx_byte
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [11:0] cursor_x, [23:12] cursor_y, [35:24] prior_x, [47:36] prior_y,
    // [56:48] move_x, [65:57] move_y, [66] left_button, [67] right_button,
    // [68] middle_button, [71:69] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  cfg_reg_t               cfg_index,
    input  logic [SIZE_BITS-1:0]   cfg_data
);

    logic [SIZE_BITS-1:0]  width_reg;
    logic [SIZE_BITS-1:0]  height_reg;
    byte_pos_t             byte_pos_reg;
    logic [BYTE_BITS-1:0]  header_reg;
    logic [BYTE_BITS-1:0]  x_byte_reg;
    logic [COORD_BITS-1:0] pos_x_reg;
    logic [COORD_BITS-1:0] pos_y_reg;
    logic                  out_valid_reg;
    result_t               out_reg;

    result_t               calc;
    logic                  s_acc;
    logic                  m_acc;
    logic                  produce;

    ps2mct_cursor_calc u_calc (
        .header        (header_reg),
        .x_byte        (x_byte_reg),
        .y_byte        (s_axis_tdata),
        .pos_x         (pos_x_reg),
        .pos_y         (pos_y_reg),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .result        (calc)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = ~out_valid_reg | m_axis_tready;
    assign s_acc         = s_axis_tvalid & s_axis_tready;
    assign m_acc         = out_valid_reg & m_axis_tready;
    assign produce       = s_acc & (byte_pos_reg == POS_Y) & ~calc.drop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg  <= POS_HEADER;
            header_reg    <= '0;
            x_byte_reg    <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_acc)
            begin
                unique case (byte_pos_reg)
                    POS_X:
                    begin
                        x_byte_reg   <= s_axis_tdata;
                        byte_pos_reg <= POS_Y;
                    end
                    POS_Y:
                    begin
                        byte_pos_reg <= POS_HEADER;
                        // overflow packets leave position untouched
                        if (!calc.drop)
                        begin
                            pos_x_reg <= calc.cursor_x;
                            pos_y_reg <= calc.cursor_y;
                        end
                    end
                    default:
                    begin
                        header_reg   <= s_axis_tdata;
                        byte_pos_reg <= POS_X;
                    end
                endcase
            end

            if (produce)
                out_valid_reg <= 1'b1;
            else if (m_acc)
                out_valid_reg <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (produce)
            out_reg <= calc;
    end

    always_comb
    begin
        m_axis_tdata            = '0;
        m_axis_tdata[OUT_W-1:0] = {out_reg.middle_button, out_reg.right_button,
                                   out_reg.left_button, out_reg.move_y, out_reg.move_x,
                                   out_reg.prior_y, out_reg.prior_x,
                                   out_reg.cursor_y, out_reg.cursor_x};
    end

    assign m_axis_tvalid = out_valid_reg;

`ifndef ASSERT_OFF
    a_produce_valid: assert property (@(posedge clk) disable iff (!rst_n)
        produce |=> m_axis_tvalid)
        else $error("result word missing after complete packet");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (m_acc && !produce) |=> !m_axis_tvalid)
        else $error("result word repeated after it was taken");

    a_pos_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_reg.cursor_x == pos_x_reg && out_reg.cursor_y == pos_y_reg))
        else $error("pending word disagrees with cursor state");

    a_byte_pos: assert property (@(posedge clk) disable iff (!rst_n)
        byte_pos_reg != 2'd3)
        else $error("byte count out of range");

    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid && !produce) |=> !m_axis_tvalid)
        else $error("result word without a packet");
`endif

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream test of the PS/2 mouse cursor tracker.
// Mouse bytes go in as three-byte packets. The bench predicts the cursor,
// button and movement word of each packet that is not dropped for overflow,
// and checks every output word against that prediction in arrival order.
// The run covers several screen sizes, from the smallest to beyond the
// coordinate range, under phases of input gaps and output back-pressure.
// ----------------------------------------------------------------------------
module tb;
    import ps2mct_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    // Tracks the packet assembly and cursor state; holds the pending words.
    class cursor_scoreboard;
        byte_pos_t             pos;
        logic [BYTE_BITS-1:0]  hdr;
        logic [BYTE_BITS-1:0]  x_move;
        logic [COORD_BITS-1:0] cur_x;
        logic [COORD_BITS-1:0] cur_y;
        logic [SIZE_BITS-1:0]  width;
        logic [SIZE_BITS-1:0]  height;
        result_t               pending_q[$];
        int                    bytes_seen;
        int                    words_ok;
        int                    dropped;
        int                    errors;

        function new();
            pos        = POS_HEADER;
            hdr        = '0;
            x_move     = '0;
            cur_x      = '0;
            cur_y      = '0;
            width      = WIDTH_RESET;
            height     = HEIGHT_RESET;
            bytes_seen = 0;
            words_ok   = 0;
            dropped    = 0;
            errors     = 0;
        endfunction

        // Zero size acts as one; sizes past the coordinate range saturate.
        function int coord_limit(logic [SIZE_BITS-1:0] size);
            int lim;
            lim = (size == 0) ? 0 : int'(size) - 1;
            if (lim > (1 << COORD_BITS) - 1)
                lim = (1 << COORD_BITS) - 1;
            return lim;
        endfunction

        function int clamp(int v, int lim);
            if (v < 0)
                v = 0;
            if (v > lim)
                v = lim;
            return v;
        endfunction

        function void set_size(cfg_reg_t idx, logic [SIZE_BITS-1:0] v);
            if (idx == REG_SCREEN_WIDTH)
                width = v;
            else
                height = v;
        endfunction

        function void note_byte(logic [BYTE_BITS-1:0] b);
            result_t r;
            int      dx;
            int      dy;
            bytes_seen++;
            case (pos)
                POS_HEADER:
                begin
                    hdr = b;
                    pos = POS_X;
                end
                POS_X:
                begin
                    x_move = b;
                    pos    = POS_Y;
                end
                default:
                begin
                    pos = POS_HEADER;
                    if (hdr[HDR_XOVF] || hdr[HDR_YOVF])
                    begin
                        dropped++;
                        return;
                    end
                    dx = int'(x_move) - (hdr[HDR_XSIGN] ? 256 : 0);
                    dy = int'(b) - (hdr[HDR_YSIGN] ? 256 : 0);
                    r  = '0;
                    r.prior_x = cur_x;
                    r.prior_y = cur_y;
                    // screen y grows downward, so an upward move subtracts
                    cur_x = COORD_BITS'(clamp(int'(cur_x) + dx, coord_limit(width)));
                    cur_y = COORD_BITS'(clamp(int'(cur_y) - dy, coord_limit(height)));
                    r.cursor_x      = cur_x;
                    r.cursor_y      = cur_y;
                    r.move_x        = MOVE_BITS'(dx);
                    r.move_y        = MOVE_BITS'(dy);
                    r.left_button   = hdr[HDR_LEFT];
                    r.right_button  = hdr[HDR_RIGHT];
                    r.middle_button = hdr[HDR_MIDDLE];
                    pending_q.push_back(r);
                end
            endcase
        endfunction

        function void check_word(logic [OUT_TDATA_W-1:0] w);
            result_t got;
            result_t want;
            string   bad;
            got = '0;
            got.cursor_x      = w[0 +: COORD_BITS];
            got.cursor_y      = w[COORD_BITS +: COORD_BITS];
            got.prior_x       = w[2*COORD_BITS +: COORD_BITS];
            got.prior_y       = w[3*COORD_BITS +: COORD_BITS];
            got.move_x        = w[4*COORD_BITS +: MOVE_BITS];
            got.move_y        = w[4*COORD_BITS + MOVE_BITS +: MOVE_BITS];
            got.left_button   = w[4*COORD_BITS + 2*MOVE_BITS];
            got.right_button  = w[4*COORD_BITS + 2*MOVE_BITS + 1];
            got.middle_button = w[4*COORD_BITS + 2*MOVE_BITS + 2];
            if (pending_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected word x=%0d y=%0d", $realtime,
                             got.cursor_x, got.cursor_y);
                return;
            end
            want = pending_q.pop_front();
            bad  = "";
            if (got.cursor_x !== want.cursor_x)           bad = {bad, " cursor_x"};
            if (got.cursor_y !== want.cursor_y)           bad = {bad, " cursor_y"};
            if (got.prior_x !== want.prior_x)             bad = {bad, " prior_x"};
            if (got.prior_y !== want.prior_y)             bad = {bad, " prior_y"};
            if (got.move_x !== want.move_x)               bad = {bad, " move_x"};
            if (got.move_y !== want.move_y)               bad = {bad, " move_y"};
            if (got.left_button !== want.left_button)     bad = {bad, " left"};
            if (got.right_button !== want.right_button)   bad = {bad, " right"};
            if (got.middle_button !== want.middle_button) bad = {bad, " middle"};
            if (bad == "")
                words_ok++;
            else
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("%0t: mismatch in%s", $realtime, bad);
                    $display("  expected x=%0d y=%0d px=%0d py=%0d mx=%0d my=%0d lrm=%b%b%b",
                             want.cursor_x, want.cursor_y, want.prior_x, want.prior_y,
                             want.move_x, want.move_y, want.left_button,
                             want.right_button, want.middle_button);
                    $display("  actual   x=%0d y=%0d px=%0d py=%0d mx=%0d my=%0d lrm=%b%b%b",
                             got.cursor_x, got.cursor_y, got.prior_x, got.prior_y,
                             got.move_x, got.move_y, got.left_button,
                             got.right_button, got.middle_button);
                end
            end
        endfunction

        function void check_leftover();
            if (pending_q.size() != 0)
            begin
                errors += pending_q.size();
                $display("%0d expected words never arrived", pending_q.size());
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_reg_t               cfg_index = REG_SCREEN_WIDTH;
    logic [SIZE_BITS-1:0]   cfg_data = '0;

    cursor_scoreboard sb = new();
    int               idle_pct = 0;
    int               stall_pct = 0;
    int               cycles = 0;

    ps2_mouse_cursor_tracker_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever
            #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: stall at random, check every word taken.
    initial
    begin
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tdata);
        end
    end

    task automatic send_byte(logic [BYTE_BITS-1:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        sb.note_byte(b);
    endtask

    task automatic send_packet(logic [7:0] h, logic [7:0] xb, logic [7:0] yb);
        send_byte(h);
        send_byte(xb);
        send_byte(yb);
    endtask

    // Half the packets drift hard toward one corner so the clamps get hit.
    task automatic send_random_packet(bit toward_max);
        logic [7:0] h;
        logic [7:0] xb;
        logic [7:0] yb;
        h  = 8'($urandom_range(255));
        xb = 8'($urandom_range(255));
        yb = 8'($urandom_range(255));
        if ($urandom_range(99) < 85)
        begin
            h[HDR_XOVF] = 1'b0;
            h[HDR_YOVF] = 1'b0;
        end
        if ($urandom_range(1) == 1)
        begin
            h[HDR_XSIGN] = !toward_max;
            h[HDR_YSIGN] = toward_max;
            xb = toward_max ? 8'($urandom_range(255, 200)) : 8'($urandom_range(55));
            yb = toward_max ? 8'($urandom_range(55)) : 8'($urandom_range(255, 200));
        end
        send_packet(h, xb, yb);
    endtask

    task automatic write_size(cfg_reg_t idx, logic [SIZE_BITS-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        sb.set_size(idx, v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Hold until every pending word is out, then let the pipe settle.
    task automatic wait_drained();
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 7; phase++)
        begin
            if (phase > 0)
            begin
                wait_drained();
                case (phase)
                    1:
                    begin
                        write_size(REG_SCREEN_WIDTH, 13'd1);
                        write_size(REG_SCREEN_HEIGHT, 13'd1);
                    end
                    2:
                    begin
                        write_size(REG_SCREEN_WIDTH, 13'd4096);
                        write_size(REG_SCREEN_HEIGHT, 13'd4096);
                    end
                    3:
                    begin
                        write_size(REG_SCREEN_WIDTH, 13'd0);
                        write_size(REG_SCREEN_HEIGHT, 13'd8191);
                    end
                    4:
                    begin
                        write_size(REG_SCREEN_WIDTH, 13'd100);
                        write_size(REG_SCREEN_HEIGHT, 13'd60);
                    end
                    5:
                    begin
                        write_size(REG_SCREEN_WIDTH, 13'($urandom_range(8191)));
                        write_size(REG_SCREEN_HEIGHT, 13'($urandom_range(8191)));
                    end
                    default:
                    begin
                        write_size(REG_SCREEN_WIDTH, 13'd640);
                        write_size(REG_SCREEN_HEIGHT, 13'd480);
                    end
                endcase
            end

            case (phase % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 61; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase

            if (phase == 0)
            begin
                send_packet(8'h09, 8'h7F, 8'h00);   // left press, right step of 127
                send_packet(8'h18, 8'h00, 8'h00);   // largest left step, clamp at 0
                send_packet(8'h20, 8'h00, 8'h00);   // largest downward step
                send_packet(8'h00, 8'hFF, 8'hFF);   // largest positive steps
                send_packet(8'h47, 8'h10, 8'h10);   // x overflow: drop
                send_packet(8'h87, 8'h10, 8'h10);   // y overflow: drop
                send_packet(8'hFF, 8'hFF, 8'hFF);   // both overflow: drop
                send_packet(8'h37, 8'hFF, 8'hFF);   // all buttons, minus one each
            end

            repeat (30) send_random_packet(phase % 2 == 0);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (8) @(posedge clk);
        sb.check_leftover();

        $display("covered %0d bytes, %0d words matched, %0d overflow packets dropped",
                 sb.bytes_seen, sb.words_ok, sb.dropped);
        $display("seven screen sizes from 0 to 8191, four gap and stall mixes, %0d errors",
                 sb.errors);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
